FILE: rtl/svt_pkg.sv
package svt_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic               ins;
		logic               rem;
		logic [VALUE_W-1:0] value;
	} upd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] min_value;
		logic [VALUE_W-1:0] max_value;
	} ends_t;

endpackage

FILE: rtl/svt_cells.sv
module svt_cells #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  svt_pkg::upd_t                 upd,
	input  logic [svt_pkg::INDEX_W-1:0]   rd_index,
	output logic [CW-1:0]                 cnt,
	output logic [CW-1:0]                 cnt_nxt,
	output logic [svt_pkg::VALUE_W-1:0]   rd_data,
	output svt_pkg::ends_t                ends_nxt
);
	import svt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int XW = CW + INDEX_W;

	// cells hold the values in descending order: cell 0 is the largest
	logic [VALUE_W-1:0] cell_q [CAPACITY];
	logic [VALUE_W-1:0] cell_d [CAPACITY];
	logic [CAPACITY-1:0] gt;
	logic [CW-1:0]      cnt_q;
	logic [VALUE_W-1:0] min_q;
	logic [VALUE_W-1:0] min_d;
	logic [XW-1:0]      pos_w;

	assign cnt = cnt_q;

	genvar k;
	generate
		for (k = 0; k < CAPACITY; k++) begin : g_cell
			assign gt[k] = (CW'(k) < cnt_q) && ($signed(cell_q[k]) > $signed(upd.value));

			always_comb begin
				cell_d[k] = cell_q[k];
				if (upd.ins) begin
					if (k == 0) begin
						if (!gt[0])
							cell_d[k] = upd.value;
					end else begin
						if (!gt[k])
							cell_d[k] = gt[(k > 0) ? k - 1 : 0] ? upd.value
								: cell_q[(k > 0) ? k - 1 : 0];
					end
				end else if (upd.rem) begin
					if (k < CAPACITY - 1)
						cell_d[k] = cell_q[(k < CAPACITY - 1) ? k + 1 : k];
				end
			end

			always_ff @(posedge clk) begin
				if (upd.ins || upd.rem)
					cell_q[k] <= cell_d[k];
			end
		end
	endgenerate

	always_comb begin
		cnt_nxt = cnt_q;
		if (upd.ins)
			cnt_nxt = cnt_q + CW'(1);
		else if (upd.rem)
			cnt_nxt = cnt_q - CW'(1);
	end

	// the minimum only moves on an insert; a removal takes the largest
	always_comb begin
		min_d = min_q;
		if (upd.ins && ((cnt_q == '0) || ($signed(upd.value) < $signed(min_q))))
			min_d = upd.value;
	end

	always_ff @(posedge clk) begin
		min_q <= min_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_comb begin
		if (cnt_nxt == '0) begin
			ends_nxt.min_value = '0;
			ends_nxt.max_value = '0;
		end else begin
			ends_nxt.min_value = min_d;
			ends_nxt.max_value = cell_d[0];
		end
	end

	// ascending index i sits at cell count-1-i
	assign pos_w   = XW'(cnt_q) - XW'(1) - XW'(rd_index);
	assign rd_data = cell_q[pos_w[AW-1:0]];

endmodule

FILE: rtl/sorted_vector_table_core.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   operation, value, index
// out      output     out_valid / out_stall read_value, min_value, max_value, count, status
//
// one item per cycle while out_stall does not hold the output; an accepted item passes
// the input register, then one pass through the cell row into the result register
// reset clears the count and the valid flags; the table starts empty
// out_stall holds a valid result register and, once the input register is full,
// raises in_stall in the same cycle
module sorted_vector_table_core #(
	parameter int CAPACITY = svt_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [svt_pkg::OP_W-1:0]      operation,
	input  logic [svt_pkg::VALUE_W-1:0]   value,
	input  logic [svt_pkg::INDEX_W-1:0]   index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [svt_pkg::VALUE_W-1:0]   read_value,
	output logic [svt_pkg::VALUE_W-1:0]   min_value,
	output logic [svt_pkg::VALUE_W-1:0]   max_value,
	output logic [svt_pkg::COUNT_W-1:0]   count,
	output logic [svt_pkg::STAT_W-1:0]    status
);
	import svt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + INDEX_W;
	localparam int EW = CW + COUNT_W;

	logic               valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [INDEX_W-1:0] index_s1;

	logic               adv;
	logic               fire;
	logic               accept;
	upd_t               upd;
	logic [CW-1:0]      cnt;
	logic [CW-1:0]      cnt_nxt;
	logic [VALUE_W-1:0] rd_data;
	ends_t              ends_nxt;
	logic               idx_ok;
	logic [STAT_W-1:0]  stat_d;
	logic [VALUE_W-1:0] rd_d;
	logic [EW-1:0]      cnt_ext;

	logic               out_valid_q;
	logic [VALUE_W-1:0] read_value_q;
	logic [VALUE_W-1:0] min_value_q;
	logic [VALUE_W-1:0] max_value_q;
	logic [COUNT_W-1:0] count_q;
	logic [STAT_W-1:0]  status_q;

	assign adv      = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= operation;
			value_s1 <= value;
			index_s1 <= index;
		end
	end

	assign idx_ok = XW'(index_s1) < XW'(cnt);

	always_comb begin
		upd.ins   = 1'b0;
		upd.rem   = 1'b0;
		upd.value = value_s1;
		stat_d    = ST_OK;
		rd_d      = '0;
		case (op_s1)
			OP_INSERT: begin
				if (cnt == CW'(CAPACITY))
					stat_d = ST_FULL;
				else
					upd.ins = fire;
			end
			OP_REMOVE: begin
				if (cnt == '0)
					stat_d = ST_EMPTY;
				else
					upd.rem = fire;
			end
			OP_READ: begin
				if (cnt == '0)
					stat_d = ST_EMPTY;
				else if (!idx_ok)
					stat_d = ST_BADIDX;
				else
					rd_d = rd_data;
			end
			default: begin
				stat_d = ST_OK;
			end
		endcase
	end

	svt_cells #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.rd_index (index_s1),
		.cnt      (cnt),
		.cnt_nxt  (cnt_nxt),
		.rd_data  (rd_data),
		.ends_nxt (ends_nxt)
	);

	// count leaves on five bits whatever the table depth
	assign cnt_ext = EW'(cnt_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rd_d;
			min_value_q  <= ends_nxt.min_value;
			max_value_q  <= ends_nxt.max_value;
			count_q      <= cnt_ext[COUNT_W-1:0];
			status_q     <= stat_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign min_value  = min_value_q;
	assign max_value  = max_value_q;
	assign count      = count_q;
	assign status     = status_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op_s1 == OP_INSERT) && (stat_d == ST_OK) |=> cnt == $past(cnt) + CW'(1))
		else $error("insert did not add an entry");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_FULL) |-> cnt == CW'(CAPACITY))
		else $error("full reported on a table with room");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $signed(min_value_q) <= $signed(max_value_q))
		else $error("minimum above maximum");
`endif

endmodule
